// File: sv/assert_macros.svh
// Assertion helpers shared by the RTL; they expand to nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define TDT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Condition must never be seen outside reset.
`define TDT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define TDT_ASSERT(lbl, prop, msg)
`define TDT_NEVER(lbl, cond, msg)
`endif
`endif

// File: sv/tdt_pkg.sv
package tdt_pkg;
	// default geometry
	localparam int COORD_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF   = 10;

	// fixed field widths
	localparam int RESAMPLE_W = 20;
	localparam int DECEL_W    = 16;
	localparam int DELAY_W    = 16;
	localparam int HEAD_W     = 16;
	localparam int SPEED_W    = 20;
	localparam int KIND_W     = 2;
	localparam int LEN_W      = 32;
	localparam int PHASE_W    = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 20;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_RESAMPLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DECEL    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DELAY    = 2'd2;

	// register reset values
	localparam logic [RESAMPLE_W-1:0] RESAMPLE_RST = 20'd307;
	localparam logic [DECEL_W-1:0]    DECEL_RST    = 16'd3072;
	localparam logic [DELAY_W-1:0]    DELAY_RST    = 16'd307;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_POINT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_LAST  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_END   = 2'd2;

	// trajectory phase
	localparam logic [PHASE_W-1:0] PH_RUN  = 2'd0;
	localparam logic [PHASE_W-1:0] PH_OVER = 2'd1;
	localparam logic [PHASE_W-1:0] PH_DONE = 2'd2;

	// status of a serial arithmetic unit
	typedef struct packed {
		logic busy;
		logic done;
	} tdt_unit_sts_t;
endpackage

// File: sv/trajectory_decimate_and_truncate_unit.sv
// One item at a time: a new point is not accepted until the sequencer is back in idle and
// any pending result can move; the bit-serial multiplier, divider and square root work
// one bit or digit a cycle each.
// Reset (arst_n low, asynchronous): configuration registers return to their defaults, the kept point,
// travelled length and limit clear to zero, phase is running and no result is pending.
`include "assert_macros.svh"

module trajectory_decimate_and_truncate_unit #(
	parameter int COORD_WIDTH = tdt_pkg::COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = tdt_pkg::FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [tdt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tdt_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [COORD_WIDTH-1:0]      pos_x,
	input  logic signed [COORD_WIDTH-1:0]      pos_y,
	input  logic signed [COORD_WIDTH-1:0]      pos_z,
	input  logic [tdt_pkg::HEAD_W-1:0]         heading,
	input  logic signed [tdt_pkg::SPEED_W-1:0] speed,
	input  logic                               first_point,
	input  logic                               last_point,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [COORD_WIDTH-1:0]      out_x,
	output logic signed [COORD_WIDTH-1:0]      out_y,
	output logic signed [COORD_WIDTH-1:0]      out_z,
	output logic [tdt_pkg::HEAD_W-1:0]         out_heading,
	output logic [tdt_pkg::KIND_W-1:0]         kind
);
	import tdt_pkg::*;

	localparam int CW  = COORD_WIDTH;
	localparam int DLW = CW + 1;
	localparam int MW  = (CW + 1 > LEN_W) ? CW + 1 : LEN_W;
	localparam int PW  = 2 * MW;
	localparam int RW  = MW + 1;
	localparam int SW  = 2 * RW;
	localparam logic [SPEED_W-1:0] V_MIN = SPEED_W'((2 ** FRAC_BITS + 99) / 100);
	localparam logic [1:0] AX_LAST = 2'd2;

	// sequencer states
	localparam int STW = 4;
	localparam logic [STW-1:0] ST_IDLE  = 4'd0;
	localparam logic [STW-1:0] ST_VV    = 4'd1;
	localparam logic [STW-1:0] ST_DV    = 4'd2;
	localparam logic [STW-1:0] ST_TV    = 4'd3;
	localparam logic [STW-1:0] ST_FEMIT = 4'd4;
	localparam logic [STW-1:0] ST_MX    = 4'd5;
	localparam logic [STW-1:0] ST_MY    = 4'd6;
	localparam logic [STW-1:0] ST_SQ2   = 4'd7;
	localparam logic [STW-1:0] ST_DEC   = 4'd8;
	localparam logic [STW-1:0] ST_MZ    = 4'd9;
	localparam logic [STW-1:0] ST_SQ3   = 4'd10;
	localparam logic [STW-1:0] ST_RM    = 4'd11;
	localparam logic [STW-1:0] ST_QD    = 4'd12;
	localparam logic [STW-1:0] ST_EMIT  = 4'd13;

	// configuration
	logic [RESAMPLE_W-1:0] resample_q;
	logic [DECEL_W-1:0]    decel_q, decel_eff;
	logic [DELAY_W-1:0]    delay_q;

	// control and trajectory state
	logic [STW-1:0]     state_q;
	logic               go_q;
	logic [PHASE_W-1:0] phase_q;
	logic [1:0]         ax_q;
	logic [LEN_W-1:0]   travelled_q, length_limit_q;
	logic [CW-1:0]      kx_q, ky_q, kz_q;

	// latched item and working values
	logic [CW-1:0]      px_q, py_q, pz_q;
	logic [HEAD_W-1:0]  head_q;
	logic               last_q;
	logic [SPEED_W-1:0] v_q;
	logic [SW-1:0]      s_q;
	logic [RW-1:0]      d2_q, d3_q;
	logic [PW-1:0]      q1_q;
	logic [CW-1:0]      ox_q, oy_q, oz_q;

	// result register
	logic               ov_q;
	logic [CW-1:0]      ox_out_q, oy_out_q, oz_out_q;
	logic [HEAD_W-1:0]  oh_out_q;
	logic [KIND_W-1:0]  kind_q;

	// datapath nets
	logic                 in_acc, ov_free;
	logic [SPEED_W-1:0]   spd_u, spd_mag, v_eff;
	logic [DLW-1:0]       dx, dy, dz, dxm, dym, dzm, sel_d, sel_m, sel_k, axis_res;
	logic [LEN_W-1:0]     remain, d2s, lim_sat;
	logic [PW:0]          lim_sum;
	logic [MW-1:0]        mul_a, mul_b;
	logic [PW-1:0]        mul_p, div_q;
	logic [RW-1:0]        div_den, sq_root;
	logic                 mul_go, div_go, sq_go;
	tdt_unit_sts_t        mul_sts, div_sts, sq_sts;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resample_q <= RESAMPLE_RST;
			decel_q    <= DECEL_RST;
			delay_q    <= DELAY_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_RESAMPLE: resample_q <= cfg_data[RESAMPLE_W-1:0];
				CFG_DECEL:    decel_q    <= cfg_data[DECEL_W-1:0];
				CFG_DELAY:    delay_q    <= cfg_data[DELAY_W-1:0];
				default: ;
			endcase
		end
	end

	// handshake
	assign ov_free  = !ov_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE) || (ov_q && out_stall);
	assign in_acc   = in_valid && !in_stall;

	// speed magnitude with the near-standstill cut
	assign spd_u     = speed;
	assign spd_mag   = spd_u[SPEED_W-1] ? (~spd_u + 1'b1) : spd_u;
	assign v_eff     = (spd_mag < V_MIN) ? '0 : spd_mag;
	assign decel_eff = (decel_q == '0) ? DECEL_W'(1) : decel_q;

	// deltas from the kept point
	assign dx  = {px_q[CW-1], px_q} - {kx_q[CW-1], kx_q};
	assign dy  = {py_q[CW-1], py_q} - {ky_q[CW-1], ky_q};
	assign dz  = {pz_q[CW-1], pz_q} - {kz_q[CW-1], kz_q};
	assign dxm = dx[DLW-1] ? (~dx + 1'b1) : dx;
	assign dym = dy[DLW-1] ? (~dy + 1'b1) : dy;
	assign dzm = dz[DLW-1] ? (~dz + 1'b1) : dz;

	// axis selection for interpolation
	always_comb begin
		unique case (ax_q)
			2'd0: begin
				sel_d = dx;
				sel_m = dxm;
				sel_k = {kx_q[CW-1], kx_q};
			end
			2'd1: begin
				sel_d = dy;
				sel_m = dym;
				sel_k = {ky_q[CW-1], ky_q};
			end
			default: begin
				sel_d = dz;
				sel_m = dzm;
				sel_k = {kz_q[CW-1], kz_q};
			end
		endcase
	end
	assign axis_res = sel_d[DLW-1] ? (sel_k - div_q[DLW-1:0]) : (sel_k + div_q[DLW-1:0]);

	// lengths
	assign remain  = length_limit_q - travelled_q;
	assign d2s     = (|d2_q[RW-1:LEN_W]) ? '1 : d2_q[LEN_W-1:0];
	assign lim_sum = {1'b0, q1_q} + (PW + 1)'(mul_p >> FRAC_BITS);
	assign lim_sat = (|lim_sum[PW:LEN_W]) ? '1 : lim_sum[LEN_W-1:0];

	// operand selection for the shared units
	always_comb begin
		unique case (state_q)
			ST_VV: begin
				mul_a = MW'(v_q);
				mul_b = MW'(v_q);
			end
			ST_TV: begin
				mul_a = MW'(delay_q);
				mul_b = MW'(v_q);
			end
			ST_MX: begin
				mul_a = MW'(dxm);
				mul_b = MW'(dxm);
			end
			ST_MY: begin
				mul_a = MW'(dym);
				mul_b = MW'(dym);
			end
			ST_MZ: begin
				mul_a = MW'(dzm);
				mul_b = MW'(dzm);
			end
			ST_RM: begin
				mul_a = MW'(remain);
				mul_b = MW'(sel_m);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end
	assign div_den = (state_q == ST_DV) ? RW'({decel_eff, 1'b0}) : d3_q;
	assign mul_go  = go_q && (state_q == ST_VV || state_q == ST_TV || state_q == ST_MX ||
		state_q == ST_MY || state_q == ST_MZ || state_q == ST_RM);
	assign div_go  = go_q && (state_q == ST_DV || state_q == ST_QD);
	assign sq_go   = go_q && (state_q == ST_SQ2 || state_q == ST_SQ3);

	tdt_mul #(.MW(MW)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_go),
		.op_a(mul_a), .op_b(mul_b), .prod(mul_p), .sts(mul_sts)
	);

	tdt_div #(.NW(PW), .DW(RW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_go),
		.num(mul_p), .den(div_den), .quo(div_q), .sts(div_sts)
	);

	tdt_sqrt #(.RW(RW)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_go),
		.rad(s_q), .root(sq_root), .sts(sq_sts)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			go_q           <= 1'b0;
			phase_q        <= PH_RUN;
			ax_q           <= '0;
			travelled_q    <= '0;
			length_limit_q <= '0;
			kx_q           <= '0;
			ky_q           <= '0;
			kz_q           <= '0;
			ov_q           <= 1'b0;
		end else begin
			go_q <= 1'b0;
			if (ov_q && !out_stall)
				ov_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (first_point) begin
							state_q <= ST_VV;
							go_q    <= 1'b1;
						end else if (phase_q != PH_RUN) begin
							if (phase_q == PH_OVER && last_point) begin
								phase_q <= PH_DONE;
								ov_q    <= 1'b1;
							end
						end else begin
							state_q <= ST_MX;
							go_q    <= 1'b1;
						end
					end
				end
				ST_VV: if (mul_sts.done) begin
					state_q <= ST_DV;
					go_q    <= 1'b1;
				end
				ST_DV: if (div_sts.done) begin
					state_q <= ST_TV;
					go_q    <= 1'b1;
				end
				ST_TV: if (mul_sts.done) begin
					// new limit and a fresh length count together
					length_limit_q <= lim_sat;
					travelled_q    <= '0;
					state_q        <= ST_FEMIT;
				end
				ST_FEMIT: if (ov_free) begin
					kx_q        <= px_q;
					ky_q        <= py_q;
					kz_q        <= pz_q;
					travelled_q <= '0;
					phase_q     <= last_q ? PH_DONE : PH_RUN;
					ov_q        <= 1'b1;
					state_q     <= ST_IDLE;
				end
				ST_MX: if (mul_sts.done) begin
					state_q <= ST_MY;
					go_q    <= 1'b1;
				end
				ST_MY: if (mul_sts.done) begin
					state_q <= ST_SQ2;
					go_q    <= 1'b1;
				end
				ST_SQ2: if (sq_sts.done)
					state_q <= ST_DEC;
				ST_DEC: begin
					if (!last_q && d2_q <= RW'(resample_q)) begin
						state_q <= ST_IDLE;
					end else if (ov_free) begin
						if (travelled_q >= length_limit_q) begin
							if (last_q) begin
								phase_q <= PH_DONE;
								ov_q    <= 1'b1;
							end else begin
								phase_q <= PH_OVER;
							end
							state_q <= ST_IDLE;
						end else if (remain <= d2s) begin
							state_q <= ST_MZ;
							go_q    <= 1'b1;
						end else begin
							kx_q        <= px_q;
							ky_q        <= py_q;
							kz_q        <= pz_q;
							travelled_q <= travelled_q + d2s;
							phase_q     <= last_q ? PH_DONE : PH_RUN;
							ov_q        <= 1'b1;
							state_q     <= ST_IDLE;
						end
					end
				end
				ST_MZ: if (mul_sts.done) begin
					state_q <= ST_SQ3;
					go_q    <= 1'b1;
				end
				ST_SQ3: if (sq_sts.done) begin
					ax_q    <= '0;
					state_q <= ST_RM;
					go_q    <= 1'b1;
				end
				ST_RM: if (mul_sts.done) begin
					state_q <= ST_QD;
					go_q    <= 1'b1;
				end
				ST_QD: if (div_sts.done) begin
					if (ax_q == AX_LAST) begin
						state_q <= ST_EMIT;
					end else begin
						ax_q    <= ax_q + 1'b1;
						state_q <= ST_RM;
						go_q    <= 1'b1;
					end
				end
				ST_EMIT: if (ov_free) begin
					phase_q <= PH_DONE;
					ov_q    <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// working registers and result payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			px_q   <= pos_x;
			py_q   <= pos_y;
			pz_q   <= pos_z;
			head_q <= heading;
			last_q <= last_point;
			v_q    <= v_eff;
			// end marker straight from the accept cycle
			ox_out_q <= '0;
			oy_out_q <= '0;
			oz_out_q <= '0;
			oh_out_q <= '0;
			kind_q   <= KIND_END;
		end
		if (state_q == ST_DV && div_sts.done)
			q1_q <= div_q;
		if (state_q == ST_MX && mul_sts.done)
			s_q <= SW'(mul_p);
		if ((state_q == ST_MY || state_q == ST_MZ) && mul_sts.done)
			s_q <= s_q + SW'(mul_p);
		if (state_q == ST_SQ2 && sq_sts.done)
			d2_q <= sq_root;
		if (state_q == ST_SQ3 && sq_sts.done)
			d3_q <= sq_root;
		if (state_q == ST_QD && div_sts.done) begin
			unique case (ax_q)
				2'd0:    ox_q <= axis_res[CW-1:0];
				2'd1:    oy_q <= axis_res[CW-1:0];
				default: oz_q <= axis_res[CW-1:0];
			endcase
		end
		// point, crossing-point and end-marker results
		if (ov_free) begin
			priority if (state_q == ST_FEMIT || (state_q == ST_DEC && !(!last_q &&
				d2_q <= RW'(resample_q)) && travelled_q < length_limit_q && remain > d2s)) begin
				ox_out_q <= px_q;
				oy_out_q <= py_q;
				oz_out_q <= pz_q;
				oh_out_q <= head_q;
				kind_q   <= last_q ? KIND_LAST : KIND_POINT;
			end else if (state_q == ST_EMIT) begin
				ox_out_q <= ox_q;
				oy_out_q <= oy_q;
				oz_out_q <= oz_q;
				oh_out_q <= head_q;
				kind_q   <= KIND_LAST;
			end else if (state_q == ST_DEC) begin
				ox_out_q <= '0;
				oy_out_q <= '0;
				oz_out_q <= '0;
				oh_out_q <= '0;
				kind_q   <= KIND_END;
			end
		end
	end

	assign out_valid   = ov_q;
	assign out_x       = ox_out_q;
	assign out_y       = oy_out_q;
	assign out_z       = oz_out_q;
	assign out_heading = oh_out_q;
	assign kind        = kind_q;

	// checks
	`TDT_ASSERT(a_units_exclusive, $onehot0({mul_sts.busy, div_sts.busy, sq_sts.busy}), "units overlap")
	`TDT_NEVER(a_travel_within_limit, travelled_q > length_limit_q, "travelled beyond limit")
	`TDT_ASSERT(a_end_marker_blank, out_valid && kind == KIND_END |-> out_x == '0 && out_heading == '0, "end marker carries data")
	`TDT_NEVER(a_busy_no_accept, state_q != ST_IDLE && in_valid && !in_stall, "item taken while busy")
endmodule

// File: sv/tdt_mul.sv
module tdt_mul #(
	parameter int MW = 33
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [MW-1:0]         op_a,
	input  logic [MW-1:0]         op_b,
	output logic [2*MW-1:0]       prod,
	output tdt_pkg::tdt_unit_sts_t sts
);
	import tdt_pkg::*;

	localparam int CNTW = $clog2(MW);
	localparam logic [CNTW-1:0] LAST = CNTW'(MW - 1);

	logic            busy_q, done_q;
	logic [CNTW-1:0] cnt_q;
	logic [MW-1:0]   a_q;
	logic [2*MW-1:0] p_q;
	logic [MW:0]     sum;

	// shift-add: one multiplier bit per cycle
	assign sum = {1'b0, p_q[2*MW-1:MW]} + (p_q[0] ? {1'b0, a_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= op_a;
			p_q <= {{MW{1'b0}}, op_b};
		end else if (busy_q) begin
			p_q <= {sum, p_q[MW-1:1]};
		end
	end

	assign prod     = p_q;
	assign sts.busy = busy_q;
	assign sts.done = done_q;
endmodule

// File: sv/tdt_div.sv
module tdt_div #(
	parameter int NW = 66,
	parameter int DW = 34
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [NW-1:0]         num,
	input  logic [DW-1:0]         den,
	output logic [NW-1:0]         quo,
	output tdt_pkg::tdt_unit_sts_t sts
);
	import tdt_pkg::*;

	localparam int CNTW = $clog2(NW);
	localparam logic [CNTW-1:0] LAST = CNTW'(NW - 1);

	logic            busy_q, done_q;
	logic [CNTW-1:0] cnt_q;
	logic [NW-1:0]   n_q;
	logic [DW-1:0]   rem_q, den_q;
	logic [DW:0]     cand, diff;
	logic            ge;

	// restoring division: one quotient bit per cycle, shifted into the dividend register
	assign cand = {rem_q, n_q[NW-1]};
	assign ge   = cand >= {1'b0, den_q};
	assign diff = cand - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			n_q   <= {n_q[NW-2:0], ge};
			rem_q <= ge ? diff[DW-1:0] : cand[DW-1:0];
		end
	end

	assign quo      = n_q;
	assign sts.busy = busy_q;
	assign sts.done = done_q;
endmodule

// File: sv/tdt_sqrt.sv
module tdt_sqrt #(
	parameter int RW = 34
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [2*RW-1:0]       rad,
	output logic [RW-1:0]         root,
	output tdt_pkg::tdt_unit_sts_t sts
);
	import tdt_pkg::*;

	localparam int SW   = 2 * RW;
	localparam int CNTW = $clog2(RW);
	localparam logic [CNTW-1:0] LAST = CNTW'(RW - 1);

	logic            busy_q, done_q;
	logic [CNTW-1:0] cnt_q;
	logic [SW-1:0]   x_q;
	logic [RW+1:0]   rem_q;
	logic [RW-1:0]   root_q;
	logic [RW+3:0]   cand, trial, diff;
	logic            ge;

	// digit recurrence: two radicand bits in, one root bit out per cycle
	assign cand  = {rem_q, x_q[SW-1 -: 2]};
	assign trial = {2'b00, root_q, 2'b01};
	assign ge    = cand >= trial;
	assign diff  = cand - trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			x_q    <= {x_q[SW-3:0], 2'b00};
			root_q <= {root_q[RW-2:0], ge};
			rem_q  <= ge ? diff[RW+1:0] : cand[RW+1:0];
		end
	end

	assign root     = root_q;
	assign sts.busy = busy_q;
	assign sts.done = done_q;
endmodule

// File: tb/tdt_checker.sv
`timescale 1ns / 1ps

module tdt_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	input  logic                               cfg_ready,
	input  logic [tdt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tdt_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                               in_valid,
	input  logic                               in_stall,
	input  logic signed [31:0]                 pos_x,
	input  logic signed [31:0]                 pos_y,
	input  logic signed [31:0]                 pos_z,
	input  logic [tdt_pkg::HEAD_W-1:0]         heading,
	input  logic signed [tdt_pkg::SPEED_W-1:0] speed,
	input  logic                               first_point,
	input  logic                               last_point,
	input  logic                               out_valid,
	input  logic                               out_stall,
	input  logic signed [31:0]                 out_x,
	input  logic signed [31:0]                 out_y,
	input  logic signed [31:0]                 out_z,
	input  logic [tdt_pkg::HEAD_W-1:0]         out_heading,
	input  logic [tdt_pkg::KIND_W-1:0]         kind,
	output int                                 n_fail,
	output int                                 n_pending
);
	import tdt_pkg::*;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic [15:0]        h;
		logic [1:0]         k;
	} pt_t;

	localparam logic [63:0] SAT32 = 64'hFFFF_FFFF;

	pt_t         emitted_q[$];
	logic [19:0] spacing;
	logic [15:0] decel;
	logic [15:0] delay;
	logic signed [63:0] kx, ky, kz;
	logic [63:0] dist_sum, brake_len;
	logic [1:0]  ph;

	function automatic logic [63:0] isqrt(logic [127:0] v);
		logic [63:0]  r;
		logic [63:0]  t;
		r = 0;
		for (int b = 63; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if ({64'd0, t} * {64'd0, t} <= v)
				r = t;
		end
		return r;
	endfunction

	function automatic logic signed [63:0] step_toward(logic signed [63:0] base,
			logic signed [63:0] d, logic [63:0] remain, logic [63:0] d3);
		logic [127:0] off;
		logic [63:0]  m;
		m = d < 0 ? -d : d;
		off = (d3 == 0) ? 128'd0 : ({64'd0, remain} * {64'd0, m}) / {64'd0, d3};
		return d < 0 ? base - $signed(off[63:0]) : base + $signed(off[63:0]);
	endfunction

	// append one expected item
	function automatic void expect_item(pt_t r);
		emitted_q.insert(emitted_q.size(), r);
	endfunction

	// predict the result of one accepted point
	task automatic predict_point();
		logic signed [63:0] px, py, pz, dx, dy, dz;
		logic [63:0]  v, a, lim, d2, d2s, remain, d3, mx, my, mz;
		logic [127:0] s2;
		pt_t          r;
		px = pos_x; py = pos_y; pz = pos_z;
		if (first_point) begin
			v = speed < 0 ? -64'(speed) : 64'(speed);
			a = decel == 0 ? 64'd1 : 64'(decel);
			if (v * 100 < 1024)
				v = 0;
			lim = (v * v) / (2 * a) + ((64'(delay) * v) >> 10);
			brake_len = lim > SAT32 ? SAT32 : lim;
			kx = px; ky = py; kz = pz;
			dist_sum = 0;
			ph = last_point ? PH_DONE : PH_RUN;
			r = '{pos_x, pos_y, pos_z, heading, last_point ? KIND_LAST : KIND_POINT};
			expect_item(r);
			return;
		end
		if (ph != PH_RUN) begin
			if (ph == PH_OVER && last_point) begin
				ph = PH_DONE;
				expect_item('{0, 0, 0, 0, KIND_END});
			end
			return;
		end
		dx = px - kx; dy = py - ky; dz = pz - kz;
		mx = dx < 0 ? -dx : dx; my = dy < 0 ? -dy : dy; mz = dz < 0 ? -dz : dz;
		s2 = {64'd0, mx} * {64'd0, mx} + {64'd0, my} * {64'd0, my};
		d2 = isqrt(s2);
		if (!last_point && d2 <= 64'(spacing))
			return;
		if (dist_sum >= brake_len) begin
			if (last_point) begin
				ph = PH_DONE;
				expect_item('{0, 0, 0, 0, KIND_END});
			end else
				ph = PH_OVER;
			return;
		end
		remain = brake_len - dist_sum;
		d2s = d2 > SAT32 ? SAT32 : d2;
		if (remain <= d2s) begin
			d3 = isqrt(s2 + {64'd0, mz} * {64'd0, mz});
			r.x = 32'(step_toward(kx, dx, remain, d3));
			r.y = 32'(step_toward(ky, dy, remain, d3));
			r.z = 32'(step_toward(kz, dz, remain, d3));
			r.h = heading;
			r.k = KIND_LAST;
			expect_item(r);
			ph = PH_DONE;
			return;
		end
		kx = px; ky = py; kz = pz;
		dist_sum += d2s;
		ph = last_point ? PH_DONE : PH_RUN;
		expect_item('{pos_x, pos_y, pos_z, heading,
			last_point ? KIND_LAST : KIND_POINT});
	endtask

	// watch the channels at each rising edge
	always @(posedge clk or negedge arst_n) begin
		pt_t e;
		if (!arst_n) begin
			spacing = RESAMPLE_RST; decel = DECEL_RST; delay = DELAY_RST;
			kx = 0; ky = 0; kz = 0; dist_sum = 0; brake_len = 0; ph = PH_RUN;
			emitted_q.delete();
			n_fail = 0;
			n_pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_RESAMPLE: spacing = cfg_data;
					CFG_DECEL:    decel = cfg_data[15:0];
					CFG_DELAY:    delay = cfg_data[15:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (emitted_q.size() == 0) begin
					n_fail++;
					if (n_fail <= 10)
						$display("unexpected item: x=%0d y=%0d z=%0d h=%0d kind=%0d",
							out_x, out_y, out_z, out_heading, kind);
				end else begin
					e = emitted_q.pop_front();
					if (e.x !== out_x || e.y !== out_y || e.z !== out_z ||
							e.h !== out_heading || e.k !== kind) begin
						n_fail++;
						if (n_fail <= 10)
							$display("mismatch: exp x=%0d y=%0d z=%0d h=%0d k=%0d / got x=%0d y=%0d z=%0d h=%0d k=%0d",
								e.x, e.y, e.z, e.h, e.k,
								out_x, out_y, out_z, out_heading, kind);
					end
				end
			end
			if (in_valid && !in_stall)
				predict_point();
			n_pending = emitted_q.size();
		end
	end
endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import tdt_pkg::*;

	localparam int WATCH_LIMIT = 40000;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = CFG_RESAMPLE;
	logic [19:0] cfg_data = 0;
	logic        in_valid = 0;
	logic        in_stall;
	logic signed [31:0] pos_x = 0, pos_y = 0, pos_z = 0;
	logic [15:0] heading = 0;
	logic signed [19:0] speed = 0;
	logic        first_point = 0, last_point = 0;
	logic        out_valid;
	logic        out_stall = 0;
	logic signed [31:0] out_x, out_y, out_z;
	logic [15:0] out_heading;
	logic [1:0]  kind;
	int          n_fail, n_pending;
	int          idle_pct = 8;
	bit          hold_rx = 0;
	int          quiet = 0;

	always #5 clk = ~clk;

	trajectory_decimate_and_truncate_unit i_dut (.*);

	tdt_checker i_chk (.*);

	// receiver stall, with one long hold-off on request
	always @(negedge clk) begin
		if (hold_rx)
			out_stall <= 1;
		else
			out_stall <= ($urandom_range(99) < idle_pct);
	end

	// watchdog on accepted items
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= WATCH_LIMIT) begin
			$display("** trajectory_decimate_and_truncate_unit: FAILED **");
			$finish;
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [19:0] val);
		@(negedge clk);
		cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	task automatic drain();
		while (n_pending != 0) @(posedge clk);
		repeat (500) @(posedge clk);
	endtask

	// offer one point and wait for acceptance
	task automatic send_point(logic signed [31:0] x, y, z, logic [15:0] h,
			logic signed [19:0] v, bit f, bit l);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) @(negedge clk);
		in_valid <= 1;
		pos_x <= x; pos_y <= y; pos_z <= z; heading <= h; speed <= v;
		first_point <= f; last_point <= l;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
		in_valid <= 0;
	endtask

	function automatic logic signed [31:0] rnd32();
		return $signed($urandom());
	endfunction

	// one trajectory of well-formed points with random content
	task automatic send_path(int npts, int stepmax, bit wild);
		logic signed [31:0] x, y, z;
		logic signed [19:0] v;
		x = wild ? rnd32() : $signed(32'($urandom_range(200000)) - 100000);
		y = wild ? rnd32() : $signed(32'($urandom_range(200000)) - 100000);
		z = $signed(32'($urandom_range(20000)) - 10000);
		v = ($urandom_range(9) == 0) ? $signed(20'($urandom())) :
			$signed(20'($urandom_range(40000) - 20000));
		if ($urandom_range(9) == 0)
			v = $signed(20'($urandom_range(20) - 10));
		send_point(x, y, z, 16'($urandom()), v, 1, npts == 1);
		for (int i = 1; i < npts; i++) begin
			x += wild ? rnd32() : $signed(32'($urandom_range(2 * stepmax)) - stepmax);
			y += wild ? rnd32() : $signed(32'($urandom_range(2 * stepmax)) - stepmax);
			z += $signed(32'($urandom_range(400)) - 200);
			send_point(x, y, z, 16'($urandom()), $signed(20'($urandom())), 0, i == npts - 1);
		end
	endtask

	initial begin
		int sent;
		int n;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;

		// points against the reset state, before any first point
		send_point(1000, 1000, 0, 16'h1234, 0, 0, 0);
		send_point(-5000, 3000, 7, 16'hFFFF, 0, 0, 1);
		// directed: extremes, single point, zero limit, full range speeds
		send_point(32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 16'hFFFF,
			20'sh7FFFF, 1, 1);
		send_point(32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 16'h0000,
			20'sh80000, 1, 0);
		send_point(32'sh7FFFFFFF, 32'sh80000000, 0, 16'hAAAA, 0, 0, 0);
		send_point(32'sh80000000, 32'sh7FFFFFFF, 0, 16'h5555, 0, 0, 1);
		send_point(0, 0, 0, 1, 20'sd5, 1, 0);
		send_point(5000, 0, 0, 2, 0, 0, 0);
		send_point(9000, 0, 0, 3, 0, 0, 0);
		send_point(9100, 0, 0, 4, 0, 0, 1);
		send_point(0, 0, 0, 5, 0, 0, 1);
		send_point(0, 0, 0, 6, -20'sd20000, 1, 0);
		send_point(100, 100, 0, 7, 0, 0, 0);
		send_point(3000, 0, 500, 8, 0, 0, 0);
		send_point(3000000, 2000000, -900000, 9, 0, 0, 0);
		send_point(3000001, 2000000, 0, 10, 0, 0, 1);
		sent = 16;
		drain();

		// random phases across register settings
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin write_reg(CFG_RESAMPLE, 0); write_reg(CFG_DECEL, 1);
					write_reg(CFG_DELAY, 0); end
				1: begin write_reg(CFG_RESAMPLE, 20'hFFFFF); write_reg(CFG_DECEL, 16'hFFFF);
					write_reg(CFG_DELAY, 16'hFFFF); end
				2: begin write_reg(CFG_RESAMPLE, 20'($urandom_range(2000)));
					write_reg(CFG_DECEL, 0); write_reg(CFG_DELAY, 16'($urandom())); end
				default: begin write_reg(CFG_RESAMPLE, 20'($urandom_range(3000)));
					write_reg(CFG_DECEL, 16'($urandom_range(8000) + 1));
					write_reg(CFG_DELAY, 16'($urandom_range(4000))); end
			endcase
			idle_pct = (ph == 3) ? 0 : 8;
			if (ph == 4)
				fork
					begin
						hold_rx = 1;
						repeat (3000) @(posedge clk);
						hold_rx = 0;
					end
				join_none
			while (sent < 16 + (ph + 1) * 240) begin
				n = $urandom_range(12) + 1;
				if ($urandom_range(9) == 0) begin
					// noise: stray points without framing
					send_point(rnd32(), rnd32(), rnd32(), 16'($urandom()),
						$signed(20'($urandom())), 0, $urandom_range(1));
					n = 1;
				end else
					send_path(n, ($urandom_range(3) == 0) ? 20000 : 3000,
						$urandom_range(15) == 0);
				sent += n;
			end
			drain();
		end
		if (n_fail == 0)
			$display("** trajectory_decimate_and_truncate_unit: PASSED **");
		else
			$display("** trajectory_decimate_and_truncate_unit: FAILED **");
		$finish;
	end
endmodule

// File: filelist.f
+incdir+sv
sv/tdt_pkg.sv
sv/tdt_mul.sv
sv/tdt_div.sv
sv/tdt_sqrt.sv
sv/trajectory_decimate_and_truncate_unit.sv
tb/tdt_checker.sv
tb/tb_top.sv
